>>> rtl/keg_pkg.sv
// ----------------------------------------------------------------------------
// keg_pkg
// Shared types and constants of the Kronecker edge generator.
// ----------------------------------------------------------------------------
package keg_pkg;

  localparam int MaxVertexBits = 32;

  localparam int SampleW   = 32;
  localparam int VertexW   = 32;
  localparam int VbitsW    = 6;
  localparam int CfgIndexW = 2;
  localparam int CfgDataW  = 32;

  localparam logic [VbitsW-1:0]  VertexBitsRst    = 6'd16;
  localparam logic [SampleW-1:0] LimitZeroZeroRst = 32'd2448131359;
  localparam logic [SampleW-1:0] LimitZeroOneRst  = 32'd3264175145;
  localparam logic [SampleW-1:0] LimitOneZeroRst  = 32'd4080218931;

  typedef enum logic [CfgIndexW-1:0] {
    CfgVertexBits    = 2'd0,
    CfgLimitZeroZero = 2'd1,
    CfgLimitZeroOne  = 2'd2,
    CfgLimitOneZero  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic src_bit;
    logic dst_bit;
  } quad_t;

  typedef struct packed {
    logic done;
    logic self_loop;
  } edge_status_t;

endpackage

>>> rtl/keg_quadrant.sv
// ----------------------------------------------------------------------------
// keg_quadrant
// Picks the quadrant of one level from a sample and three thresholds.
// ----------------------------------------------------------------------------
module keg_quadrant (
  input  logic [keg_pkg::SampleW-1:0] sample_i,
  input  logic [keg_pkg::SampleW-1:0] limit_zz_i,
  input  logic [keg_pkg::SampleW-1:0] limit_zo_i,
  input  logic [keg_pkg::SampleW-1:0] limit_oz_i,
  output keg_pkg::quad_t              quad_o
);

  always_comb begin
    if (sample_i < limit_zz_i) begin
      quad_o = '{src_bit: 1'b0, dst_bit: 1'b0};
    end else if (sample_i < limit_zo_i) begin
      quad_o = '{src_bit: 1'b0, dst_bit: 1'b1};
    end else if (sample_i < limit_oz_i) begin
      quad_o = '{src_bit: 1'b1, dst_bit: 1'b0};
    end else begin
      quad_o = '{src_bit: 1'b1, dst_bit: 1'b1};
    end
  end

endmodule

>>> rtl/keg_accum.sv
// ----------------------------------------------------------------------------
// keg_accum
// Gathers the vertex bits of one edge and bit-reverses them at its end.
// ----------------------------------------------------------------------------
module keg_accum #(
  parameter int MaxVertexBits = keg_pkg::MaxVertexBits,
  localparam int LvlW = $clog2(MaxVertexBits + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  keg_pkg::quad_t             quad_i,
  input  logic [LvlW-1:0]            levels_i,
  output keg_pkg::edge_status_t      status_o,
  output logic [MaxVertexBits-1:0]   src_o,
  output logic [MaxVertexBits-1:0]   dst_o
);

  logic [LvlW-1:0]          level_q, level_d, level_inc;
  logic [MaxVertexBits-1:0] src_q, src_d, src_next;
  logic [MaxVertexBits-1:0] dst_q, dst_d, dst_next;
  logic [MaxVertexBits-1:0] src_rev, dst_rev;
  logic [LvlW-1:0]          shift_amt;

  assign level_inc = level_q + LvlW'(1);
  assign src_next  = (src_q << 1) | MaxVertexBits'(quad_i.src_bit);
  assign dst_next  = (dst_q << 1) | MaxVertexBits'(quad_i.dst_bit);

  always_comb begin
    for (int i = 0; i < MaxVertexBits; i++) begin
      src_rev[MaxVertexBits-1-i] = src_next[i];
      dst_rev[MaxVertexBits-1-i] = dst_next[i];
    end
  end

  assign shift_amt = LvlW'(MaxVertexBits) - levels_i;
  assign src_o     = src_rev >> shift_amt;
  assign dst_o     = dst_rev >> shift_amt;

  assign status_o.done      = (level_inc >= levels_i);
  assign status_o.self_loop = (src_o == dst_o);

  always_comb begin
    level_d = level_q;
    src_d   = src_q;
    dst_d   = dst_q;
    if (step_i) begin
      if (status_o.done) begin
        level_d = '0;
        src_d   = '0;
        dst_d   = '0;
      end else begin
        level_d = level_inc;
        src_d   = src_next;
        dst_d   = dst_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      src_q   <= '0;
      dst_q   <= '0;
    end else begin
      level_q <= level_d;
      src_q   <= src_d;
      dst_q   <= dst_d;
    end
  end

endmodule

>>> rtl/kronecker_edge_generator.sv
// ----------------------------------------------------------------------------
// kronecker_edge_generator
// R-MAT edge generator: one random sample per level, one edge per run of
// levels, self loops dropped.
// ----------------------------------------------------------------------------
// Channel  Direction  Payload
// s_axis   in         tdata[31:0] random_sample
// m_axis   out        tdata[31:0] source_vertex, tdata[63:32] target_vertex
// cfg      in         cfg_index_i register index, cfg_data_i value
//
// A sample is taken every cycle while the result register is not stalled;
// the sample register feeds the compare and the vertex registers, and an
// edge is written into the result register from its last sample.
// A stalled result register holds the sample register, which then stops
// taking samples. Reset restores the register defaults and empties both
// stages; the configuration port is always ready.
// ----------------------------------------------------------------------------
module kronecker_edge_generator #(
  parameter int MaxVertexBits = keg_pkg::MaxVertexBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [keg_pkg::SampleW-1:0]   s_axis_tdata,   // [31:0] random_sample
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [2*keg_pkg::VertexW-1:0] m_axis_tdata,   // [31:0] source, [63:32] target
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [keg_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [keg_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int LvlW = $clog2(MaxVertexBits + 1);

  logic [keg_pkg::VbitsW-1:0]  vbits_q;
  logic [keg_pkg::SampleW-1:0] limit_zz_q, limit_zo_q, limit_oz_q;
  logic [LvlW-1:0]             levels;

  logic                        in_valid_q;
  logic [keg_pkg::SampleW-1:0] sample_q;
  logic                        out_valid_q, out_valid_d;
  logic [keg_pkg::VertexW-1:0] out_src_q, out_dst_q;

  logic                        advance;
  logic                        step;
  keg_pkg::quad_t              quad;
  keg_pkg::edge_status_t       status;
  logic [MaxVertexBits-1:0]    src_full, dst_full;
  logic                        emit;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vbits_q    <= keg_pkg::VertexBitsRst;
      limit_zz_q <= keg_pkg::LimitZeroZeroRst;
      limit_zo_q <= keg_pkg::LimitZeroOneRst;
      limit_oz_q <= keg_pkg::LimitOneZeroRst;
    end else if (cfg_valid_i) begin
      case (keg_pkg::cfg_reg_e'(cfg_index_i))
        keg_pkg::CfgVertexBits:    vbits_q    <= cfg_data_i[keg_pkg::VbitsW-1:0];
        keg_pkg::CfgLimitZeroZero: limit_zz_q <= cfg_data_i[keg_pkg::SampleW-1:0];
        keg_pkg::CfgLimitZeroOne:  limit_zo_q <= cfg_data_i[keg_pkg::SampleW-1:0];
        keg_pkg::CfgLimitOneZero:  limit_oz_q <= cfg_data_i[keg_pkg::SampleW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (vbits_q == '0) begin
      levels = LvlW'(1);
    end else if (int'(vbits_q) > MaxVertexBits) begin
      levels = LvlW'(MaxVertexBits);
    end else begin
      levels = LvlW'(vbits_q);
    end
  end

  assign advance       = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      sample_q <= s_axis_tdata;
    end
  end

  keg_quadrant u_quadrant (
    .sample_i   (sample_q),
    .limit_zz_i (limit_zz_q),
    .limit_zo_i (limit_zo_q),
    .limit_oz_i (limit_oz_q),
    .quad_o     (quad)
  );

  keg_accum #(
    .MaxVertexBits (MaxVertexBits)
  ) u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .quad_i   (quad),
    .levels_i (levels),
    .status_o (status),
    .src_o    (src_full),
    .dst_o    (dst_full)
  );

  assign emit = step && status.done && !status.self_loop;

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_src_q <= keg_pkg::VertexW'(src_full);
      out_dst_q <= keg_pkg::VertexW'(dst_full);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_dst_q, out_src_q};

endmodule
